>>> rtl/tel_pkg.sv
package tel_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int DELAY_W = 16;
	localparam int ID_W    = 8;
	localparam int KIND_W  = 2;
	localparam int ENTRY_W = DELAY_W + ID_W;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_FULL     = 2'd1,
		KIND_FIRED    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_in;
		logic rd_entry;
		logic eval_entry;
		logic emit_rd;
		logic emit_wr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_tick;
		logic count_zero;
		logic walk_last;
		logic fired_any;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

>>> rtl/tel_in_if.sv
interface tel_in_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [tel_pkg::DELAY_W-1:0] delay_ticks;
	logic [tel_pkg::ID_W-1:0]    event_id;

	modport source (output valid, output mode, output delay_ticks, output event_id,
		input ready);
	modport sink (input valid, input mode, input delay_ticks, input event_id,
		output ready);
endinterface

>>> rtl/tel_out_if.sv
interface tel_out_if;
	logic                        valid;
	logic                        ready;
	logic [tel_pkg::KIND_W-1:0] result_kind;
	logic [tel_pkg::ID_W-1:0]   fired_id;
	logic                        last_of_run;

	modport source (output valid, output result_kind, output fired_id,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input fired_id,
		input last_of_run, output ready);
endinterface

>>> rtl/tel_ram.sv
module tel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tel_ctrl.sv
module tel_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tel_pkg::status_t st,
	output tel_pkg::cmd_t    cmd
);
	import tel_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = st.out_free;
				if (in_valid && st.out_free) begin
					cmd.take_in = 1'b1;
					if (st.in_tick && !st.count_zero) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_entry = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval_entry = 1'b1;
				if (!st.walk_last) begin
					state_d = ST_READ;
				end else if (st.fired_any) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (st.out_free) begin
					cmd.emit_wr = 1'b1;
					state_d     = st.emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/tel_dp.sv
module tel_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tel_pkg::cmd_t               cmd,
	output tel_pkg::status_t            st,
	input  logic                        in_mode,
	input  logic [tel_pkg::DELAY_W-1:0] in_delay,
	input  logic [tel_pkg::ID_W-1:0]    in_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tel_pkg::kind_t              out_kind,
	output logic [tel_pkg::ID_W-1:0]    out_id,
	output logic                        out_last
);
	import tel_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] keep_q;
	logic [CNT_W-1:0] nfired_q;
	logic [CNT_W-1:0] nfired_m1;

	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_last_q;

	logic               tab_we;
	logic [IDX_W-1:0]   tab_waddr;
	logic [ENTRY_W-1:0] tab_wdata;
	logic [ENTRY_W-1:0] tab_rdata;
	logic [DELAY_W-1:0] ent_cd;
	logic [ID_W-1:0]    ent_id;
	logic [ID_W-1:0]    stk_rdata;

	logic is_append;
	logic has_room;
	logic do_store;
	logic fire_now;

	assign is_append = cmd.take_in && (in_mode == MODE_APPEND);
	assign has_room  = (count_q < CNT_W'(SLOTS));
	assign do_store  = is_append && (in_id != '0) && has_room;
	assign ent_cd    = tab_rdata[ID_W +: DELAY_W];
	assign ent_id    = tab_rdata[ID_W-1:0];
	assign fire_now  = (ent_cd == '0);
	assign nfired_m1 = nfired_q - CNT_W'(1);

	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = count_q[IDX_W-1:0];
		tab_wdata = {in_delay, in_id};
		if (do_store) begin
			tab_we = 1'b1;
		end else if (cmd.eval_entry && !fire_now) begin
			tab_we    = 1'b1;
			tab_waddr = keep_q[IDX_W-1:0];
			tab_wdata = {ent_cd - DELAY_W'(1), ent_id};
		end
	end

	tel_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (cmd.rd_entry),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (tab_rdata)
	);

	// fired ids, read back newest first
	tel_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_stack (
		.clk   (clk),
		.we    (cmd.eval_entry && fire_now),
		.waddr (nfired_q[IDX_W-1:0]),
		.wdata (ent_id),
		.re    (cmd.emit_rd),
		.raddr (nfired_m1[IDX_W-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			keep_q   <= '0;
			nfired_q <= '0;
		end else begin
			if (do_store) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.take_in && (in_mode == MODE_TICK)) begin
				idx_q    <= '0;
				keep_q   <= '0;
				nfired_q <= '0;
			end
			if (cmd.eval_entry) begin
				idx_q <= idx_q + CNT_W'(1);
				if (fire_now) begin
					nfired_q <= nfired_q + CNT_W'(1);
				end else begin
					keep_q <= keep_q + CNT_W'(1);
				end
				if (st.walk_last) begin
					count_q <= fire_now ? keep_q : keep_q + CNT_W'(1);
				end
			end
			if (cmd.emit_wr) begin
				nfired_q <= nfired_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_append || cmd.emit_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_append) begin
			out_kind_q <= ((in_id == '0) || has_room) ? KIND_ACCEPTED : KIND_FULL;
			out_id_q   <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_wr) begin
			out_kind_q <= KIND_FIRED;
			out_id_q   <= stk_rdata;
			out_last_q <= (nfired_q == CNT_W'(1));
		end
	end

	always_comb begin
		st.in_tick    = (in_mode == MODE_TICK);
		st.count_zero = (count_q == '0);
		st.walk_last  = ((idx_q + CNT_W'(1)) == count_q);
		st.fired_any  = (nfired_q != '0) || fire_now;
		st.out_free   = !out_valid_q || out_ready;
		st.emit_last  = (nfired_q == CNT_W'(1));
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_id    = out_id_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/timed_event_list.sv
// Timed event list: a table of up to SLOTS pending events (countdown, id),
// kept compacted in append order.
// Channel "request" carries mode, delay_ticks and event_id. An append
// (mode 0) stores the event at the tail and answers one result: accepted,
// or refused when the table is full. Id zero stores nothing and is accepted.
// A tick (mode 1) walks every stored entry: a zero countdown fires and is
// removed, the rest count down by one and move up to close the gap.
// Channel "result" carries result_kind, fired_id and last_of_run. Fired ids
// leave newest first; the final one has last_of_run set. A tick that fires
// nothing answers no result.
// An append result is registered and shown the cycle after the request is taken.
// A tick walks the stored entries with one table RAM read and one evaluate per
// entry, then emits each fired id with one stack RAM read and one output load,
// and the output load waits while the output is stalled.
// Reset empties the table at once; no clearing pass is needed since only
// entries below the fill count are ever read.
// A stalled receiver holds the output register; appends and emission wait
// until it is taken, while a walk in progress runs on.
module timed_event_list (
	input  logic    clk,
	input  logic    arst_n,
	tel_in_if.sink  request,
	tel_out_if.source result
);
	import tel_pkg::*;

	cmd_t    cmd;
	status_t st;
	kind_t   out_kind;

	// sequencer: accept, walk entries, emit fired ids
	tel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// table, fired-id stack, counters and output register
	tel_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_mode   (request.mode),
		.in_delay  (request.delay_ticks),
		.in_id     (request.event_id),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_kind  (out_kind),
		.out_id    (result.fired_id),
		.out_last  (result.last_of_run)
	);

	assign result.result_kind = out_kind;

endmodule

>>> rtl/tel_checker.sv
module tel_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_mode,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tel_pkg::KIND_W-1:0] out_kind,
	input logic [tel_pkg::ID_W-1:0]   out_id,
	input logic                        out_last
);
	import tel_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_id)
			&& $stable(out_last))
		else $error("stalled result changed");

	// an append answers on the next cycle with a single marked result
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == MODE_APPEND) |=> out_valid && out_last
			&& (out_kind != KIND_FIRED))
		else $error("append result missing");

	// append answers carry no id and end their run
	a_append_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_FIRED) |-> out_last && (out_id == '0)
			&& (out_kind == KIND_ACCEPTED || out_kind == KIND_FULL))
		else $error("bad append result");

	// no new request is taken while a result sits stalled
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken over stalled result");

endmodule

bind timed_event_list tel_checker u_tel_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (request.valid),
	.in_ready  (request.ready),
	.in_mode   (request.mode),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.result_kind),
	.out_id    (result.fired_id),
	.out_last  (result.last_of_run)
);
